// ===== rtl/core/cbip_pkg.sv =====
// Shared types, constants and character helpers for the custom base integer parser.
package cbip_pkg;

   localparam int CHAR_BITS       = 8;
   localparam int ALPHA_SLOTS     = 16;
   localparam int HALF_SLOTS      = 8;
   localparam int RADIX_BITS      = 5;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int RESULT_BITS     = 32;
   localparam int DEF_MAX_DIGITS  = 16;
   localparam int DEF_VALUE_BITS  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_LOW   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_LENGTH = 2'd2;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

   typedef logic [ALPHA_SLOTS-1:0][CHAR_BITS-1:0] alphabet_type;

   function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic is_sign(input logic [CHAR_BITS-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

endpackage

// ===== rtl/core/cbip_alphabet_check.sv =====
// Validity check of the configured digit alphabet.
module cbip_alphabet_check #(
   parameter int MAX_DIGITS = cbip_pkg::DEF_MAX_DIGITS
) (
   input  cbip_pkg::alphabet_type                alphabet,
   input  logic [cbip_pkg::RADIX_BITS-1:0]       radix,
   output logic                                  alphabet_ok
);

   // The alphabet is good when its length is in range and every character in
   // use is nonzero, not a sign or blank, and appears only once.
   always_comb begin
      alphabet_ok = (radix >= 5'd2) && (radix <= cbip_pkg::RADIX_BITS'(MAX_DIGITS));
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (cbip_pkg::RADIX_BITS'(i) < radix) begin
            if (alphabet[i] == cbip_pkg::CH_NUL || cbip_pkg::is_sign(alphabet[i]) ||
                cbip_pkg::is_blank(alphabet[i])) begin
               alphabet_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_DIGITS; j++) begin
               if (cbip_pkg::RADIX_BITS'(j) < radix && alphabet[j] == alphabet[i]) begin
                  alphabet_ok = 1'b0;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/core/cbip_digit_lookup.sv =====
// Parallel match of one character against the alphabet, lowest position wins.
module cbip_digit_lookup #(
   parameter int MAX_DIGITS = cbip_pkg::DEF_MAX_DIGITS,
   parameter int IDX_BITS   = $clog2(MAX_DIGITS)
) (
   input  cbip_pkg::alphabet_type                alphabet,
   input  logic [cbip_pkg::RADIX_BITS-1:0]       radix,
   input  logic [cbip_pkg::CHAR_BITS-1:0]        char_code,
   output logic                                  digit_hit,
   output logic [IDX_BITS-1:0]                   digit_index
);

   logic [MAX_DIGITS-1:0] match;

   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         match[k] = (cbip_pkg::RADIX_BITS'(k) < radix) && (alphabet[k] == char_code);
      end
   end

   // A zero byte is never a digit. Scanning downward leaves the lowest match.
   always_comb begin
      digit_hit   = (char_code != cbip_pkg::CH_NUL) && (|match);
      digit_index = '0;
      for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
         if (match[k]) begin
            digit_index = IDX_BITS'(k);
         end
      end
   end

endmodule

// ===== rtl/core/custom_base_integer_parser_top.sv =====
// Top level of the custom base integer parser: handshakes, parse state and result register.
//
// Usage: a string is sent on the req_ channel one character per word, and a
// word with req_terminator set closes it. Only the terminator word yields a
// result word on the rsp_ channel: the signed value in rsp_parsed_value and
// rsp_alphabet_invalid, which is set (with a zero value) when the configured
// alphabet is unusable. The user must write the alphabet and radix over the csr_
// channel (always ready) only while no string is in flight; the block does not enforce it.
//
// Throughput is one word per cycle while no blocked terminator holds the input
// register. A word taken sits in the input register and is then folded into
// the parse state; a terminator's result goes from the input register into the
// result register, which drives rsp_valid. The cycle is set by the accumulator
// update: a VALUE_BITS by 5 bit multiply-add behind the 16-way parallel digit
// match.
//
// Reset clears the parse state, the alphabet registers and both valid flags.
// When the receiver stalls, the result stays in the output register; ordinary
// characters keep flowing in, and only a second terminator waits in the input
// register until the pending result is taken.
module custom_base_integer_parser_top #(
   parameter int MAX_DIGITS = cbip_pkg::DEF_MAX_DIGITS,
   parameter int VALUE_BITS = cbip_pkg::DEF_VALUE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Input character channel.
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [cbip_pkg::CHAR_BITS-1:0]           req_char_code,
   input  logic                                     req_terminator,
   // Result channel.
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [cbip_pkg::RESULT_BITS-1:0]  rsp_parsed_value,
   output logic                                     rsp_alphabet_invalid,
   // Configuration write channel.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [cbip_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [cbip_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   localparam int IDX_BITS = $clog2(MAX_DIGITS);

   // Parse phase codes.
   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // Configuration registers.
   logic [cbip_pkg::CSR_DATA_BITS-1:0] digits_low_ff;
   logic [cbip_pkg::CSR_DATA_BITS-1:0] digits_high_ff;
   logic [cbip_pkg::RADIX_BITS-1:0]    radix_ff;
   cbip_pkg::alphabet_type             alphabet;

   // Input register.
   logic                               in_valid_ff;
   logic [cbip_pkg::CHAR_BITS-1:0]     in_char_ff;
   logic                               in_term_ff;
   logic                               stage_go;

   // Parse state.
   logic [1:0]                         phase_ff, phase_in;
   logic                               neg_ff, neg_in;
   logic [VALUE_BITS-1:0]              acc_ff, acc_in;

   // Result register.
   logic                               out_valid_ff;
   logic [cbip_pkg::RESULT_BITS-1:0]   out_value_ff, out_value_in;
   logic                               out_invalid_ff;

   logic                               alphabet_ok;
   logic                               digit_hit;
   logic [IDX_BITS-1:0]                digit_index;
   logic [VALUE_BITS-1:0]              acc_step;
   logic [VALUE_BITS-1:0]              value_signed;
   logic [cbip_pkg::RESULT_BITS-1:0]   value_fit;

   // ---------------------------------------------------------------------
   // Configuration port. Writes to an index beyond the register list are
   // accepted and dropped.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
         radix_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cbip_pkg::CSR_DIGITS_LOW:   digits_low_ff  <= csr_data;
            cbip_pkg::CSR_DIGITS_HIGH:  digits_high_ff <= csr_data;
            cbip_pkg::CSR_RADIX_LENGTH: radix_ff       <= csr_data[cbip_pkg::RADIX_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Characters 0 to 7 come from the low register, 8 to 15 from the high one.
   always_comb begin
      for (int k = 0; k < cbip_pkg::HALF_SLOTS; k++) begin
         alphabet[k] = digits_low_ff[k*cbip_pkg::CHAR_BITS +: cbip_pkg::CHAR_BITS];
         alphabet[k + cbip_pkg::HALF_SLOTS] =
            digits_high_ff[k*cbip_pkg::CHAR_BITS +: cbip_pkg::CHAR_BITS];
      end
   end

   cbip_alphabet_check #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_check (
      .alphabet    (alphabet),
      .radix       (radix_ff),
      .alphabet_ok (alphabet_ok)
   );

   cbip_digit_lookup #(
      .MAX_DIGITS (MAX_DIGITS),
      .IDX_BITS   (IDX_BITS)
   ) u_lookup (
      .alphabet    (alphabet),
      .radix       (radix_ff),
      .char_code   (in_char_ff),
      .digit_hit   (digit_hit),
      .digit_index (digit_index)
   );

   // ---------------------------------------------------------------------
   // Input register. A character word always moves on; a terminator moves
   // on only when the result register is free or being emptied.
   // ---------------------------------------------------------------------
   assign stage_go  = in_valid_ff && (!in_term_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_term_ff <= req_terminator;
      end
   end

   // ---------------------------------------------------------------------
   // Parse state. The accumulator wraps at VALUE_BITS; the multiply uses the
   // raw radix register even when it exceeds the alphabet size, since such
   // an alphabet reports as invalid anyway.
   // ---------------------------------------------------------------------
   assign acc_step = acc_ff * {{(VALUE_BITS-cbip_pkg::RADIX_BITS){1'b0}}, radix_ff}
                   + {{(VALUE_BITS-IDX_BITS){1'b0}}, digit_index};

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if (stage_go) begin
         if (in_term_ff) begin
            phase_in = PH_SPACE;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else begin
            unique case (phase_ff) inside
               PH_SPACE, PH_SIGN: begin
                  if (phase_ff == PH_SPACE && cbip_pkg::is_blank(in_char_ff)) begin
                     phase_in = PH_SPACE;
                  end else if (cbip_pkg::is_sign(in_char_ff)) begin
                     phase_in = PH_SIGN;
                     neg_in   = neg_ff ^ (in_char_ff == cbip_pkg::CH_MINUS);
                  end else if (digit_hit) begin
                     phase_in = PH_DIGIT;
                     acc_in   = acc_step;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DIGIT: begin
                  if (digit_hit) begin
                     acc_in = acc_step;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result formation: apply the sign, then fit the VALUE_BITS word to the
   // 32-bit port by sign extension or truncation.
   // ---------------------------------------------------------------------
   assign value_signed = neg_ff ? (~acc_ff + VALUE_BITS'(1)) : acc_ff;

   generate
      if (VALUE_BITS >= cbip_pkg::RESULT_BITS) begin : g_trunc
         assign value_fit = value_signed[cbip_pkg::RESULT_BITS-1:0];
      end else begin : g_extend
         assign value_fit = {{(cbip_pkg::RESULT_BITS-VALUE_BITS){value_signed[VALUE_BITS-1]}},
                             value_signed};
      end
   endgenerate

   assign out_value_in = alphabet_ok ? value_fit : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_go && in_term_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && in_term_ff) begin
         out_value_ff   <= out_value_in;
         out_invalid_ff <= !alphabet_ok;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_parsed_value     = $signed(out_value_ff);
   assign rsp_alphabet_invalid = out_invalid_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // A character word never produces a result by itself.
   a_no_result_from_char: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && !(stage_go && in_term_ff)) |=> !out_valid_ff)
      else $error("result appeared without a terminator");

   // An invalid alphabet always reports a zero value.
   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_invalid_ff) |-> (out_value_ff == '0))
      else $error("invalid alphabet with nonzero value");

   // A terminator leaves the parse state cleared.
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_go && in_term_ff) |=> (phase_ff == PH_SPACE && !neg_ff && acc_ff == '0))
      else $error("parse state not cleared after terminator");

   // A blocked terminator stays in the input register.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !stage_go) |=> (in_valid_ff && in_term_ff && $stable(in_char_ff)))
      else $error("blocked word lost from input register");

endmodule
